[rtl/bdq_pkg.sv]
package bdq_pkg;

    // default depth of the word store
    localparam int BDQ_CAPACITY = 16;

    // field widths of the stream words
    localparam int REQ_W    = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int CNT_OUT_W = 5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ_POS  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_req;  // capture the incoming request
        logic exec;      // store access and pointer update
        logic load_out;  // move the result into the output register
    } t_cmd;

endpackage

[rtl/bdq_ctrl.sv]
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd        = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/bdq_datapath.sv]
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int CAPACITY = BDQ_CAPACITY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [REQ_W-1:0]      i_req,
    input  logic [WORD_W-1:0]     i_word,
    input  logic [POS_W-1:0]      i_pos,
    output logic [WORD_W-1:0]     o_read_value,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CNT_OUT_W-1:0]  o_count,
    output logic                  o_is_empty
);

    localparam int PW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // captured request
    logic [REQ_W-1:0]    r_req;
    logic [WORD_W-1:0]   r_word;
    logic [POS_W-1:0]    r_pos;

    // ring pointers
    logic [PW-1:0]       r_head, n_head;
    logic [CW-1:0]       r_count, n_count;

    // store and its registered read
    logic [WORD_W-1:0]   mem [CAPACITY];
    logic [WORD_W-1:0]   r_rdata;
    logic                r_hit;
    logic [STATUS_W-1:0] r_status;

    // output register
    logic [WORD_W-1:0]   r_out_value;
    logic [STATUS_W-1:0] r_out_status;
    logic [CNT_OUT_W-1:0] r_out_count;
    logic                r_out_empty;

    logic                we, re;
    logic [PW-1:0]       addr;
    logic [STATUS_W-1:0] status;
    logic                full, empty;
    logic [CMPW-1:0]     pos_ext, count_ext;
    logic [31:0]         count_wide;

    // head plus offset, wrapped once
    function automatic logic [PW-1:0] slot(input logic [PW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(head) + SW'(off);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return s[PW-1:0];
    endfunction

    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign pos_ext   = CMPW'(r_pos);
    assign count_ext = CMPW'(r_count);

    always_comb begin
        n_head = r_head;
        n_count = r_count;
        we     = 1'b0;
        re     = 1'b0;
        addr   = r_head;
        status = ST_OK;
        case (r_req)
            REQ_ADD_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    n_head  = (r_head == '0) ? PW'(CAPACITY - 1) : r_head - 1'b1;
                    addr    = n_head;
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_ADD_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    addr    = slot(r_head, r_count);
                    we      = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            REQ_REM_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    addr    = r_head;
                    re      = 1'b1;
                    n_head  = (r_head == PW'(CAPACITY - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_REM_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    addr    = slot(r_head, r_count - 1'b1);
                    re      = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_READ_POS: begin
                if (pos_ext >= count_ext) begin
                    status = ST_BADPOS;
                end else begin
                    // position is below the count here, so it fits the count width
                    addr = slot(r_head, CW'(pos_ext));
                    re   = 1'b1;
                end
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= i_req;
            r_word <= i_word;
            r_pos  <= i_pos;
        end
        if (i_cmd.exec) begin
            r_hit    <= re;
            r_status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            mem[addr] <= r_word;
        end
        if (i_cmd.exec && re) begin
            r_rdata <= mem[addr];
        end
    end

    assign count_wide = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_value  <= r_hit ? r_rdata : '0;
            r_out_status <= r_status;
            r_out_count  <= count_wide[CNT_OUT_W-1:0];
            r_out_empty  <= (r_count == '0);
        end
    end

    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_is_empty   = r_out_empty;

endmodule

[rtl/bounded_array_deque_top.sv]
// steps: an accepted word is captured, then the store is accessed and head and count
//   updated, then the result is loaded into the output register once that is free; a new
//   request is taken only after the output load, the store having one registered port
// reset: synchronous active low; the list comes up empty with the head at slot zero,
//   store contents are left as they are and never read before being written
module bounded_array_deque_top
    import bdq_pkg::*;
#(
    parameter int CAPACITY = BDQ_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // new_value[31:0], position[35:32], zero pad
    input  logic [2:0]  i_s_axis_tuser,   // req_type[2:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // read_value[31:0], status[33:32],
                                          // count[38:34], is_empty[39]
);

    t_cmd                 cmd;
    logic [WORD_W-1:0]    read_value;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] count;
    logic                 is_empty;

    // controller sequences capture, store access and output load
    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    // ring store, head and count, result register
    bdq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (i_s_axis_tuser),
        .i_word       (i_s_axis_tdata[31:0]),
        .i_pos        (i_s_axis_tdata[35:32]),
        .o_read_value (read_value),
        .o_status     (status),
        .o_count      (count),
        .o_is_empty   (is_empty)
    );

    assign o_m_axis_tdata = {is_empty, count, status, read_value};

    // an accepted word moves the controller out of idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while a request is still in work");

    // the output register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result overwritten before it was taken");

    // a full report cannot come with an empty list
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[33:32] == ST_FULL)) |-> !o_m_axis_tdata[39])
        else $error("full status reported on an empty list");

endmodule

[verif/bounded_array_deque_top_test.sv]
`timescale 1ns / 100ps

module bounded_array_deque_top_test;
    import bdq_pkg::*;

    localparam int DEPTH = BDQ_CAPACITY;

    // one expected result word, fields as they sit on o_m_axis_tdata
    typedef struct packed {
        logic                 empty;
        logic [CNT_OUT_W-1:0] count;
        logic [STATUS_W-1:0]  status;
        logic [WORD_W-1:0]    value;
    } t_deque_result;

    // every input driven to a known value from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // new_value[31:0], position[35:32], zero pad
    logic [2:0]  i_s_axis_tuser = '0;   // req_type[2:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // read_value[31:0], status[33:32],
                                        // count[38:34], is_empty[39]

    // shadow copy of the list, updated at every accepted request word
    logic [WORD_W-1:0] list_words [DEPTH];
    int                list_head = 0;
    int                list_count = 0;

    t_deque_result pending_results [$];
    t_deque_result oldest_result;

    int error_count = 0;

    // idling control: percentages of cycles spent idle on each side
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // long receiver hold-off, handed over to the receiver process
    int hold_cycles = 0;
    int hold_left = 0;

    bounded_array_deque_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // apply one request to the shadow list and work out its result word
    function automatic t_deque_result deque_apply(input logic [REQ_W-1:0] kind,
                                                  input logic [WORD_W-1:0] value,
                                                  input logic [POS_W-1:0] pos);
        t_deque_result res;
        res.value  = '0;
        res.status = ST_OK;
        case (kind)
            REQ_ADD_FRONT: begin
                if (list_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_head = (list_head + DEPTH - 1) % DEPTH;
                    list_words[list_head] = value;
                    list_count++;
                end
            end
            REQ_ADD_BACK: begin
                if (list_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[(list_head + list_count) % DEPTH] = value;
                    list_count++;
                end
            end
            REQ_REM_FRONT: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = list_words[list_head];
                    list_head = (list_head + 1) % DEPTH;
                    list_count--;
                end
            end
            REQ_REM_BACK: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = list_words[(list_head + list_count - 1) % DEPTH];
                    list_count--;
                end
            end
            REQ_READ_POS: begin
                if (int'(pos) >= list_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.value = list_words[(list_head + int'(pos)) % DEPTH];
                end
            end
            default: begin
                // spare codes leave the list alone
            end
        endcase
        res.count = list_count[CNT_OUT_W-1:0];
        res.empty = (list_count == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // offer one request word, wait for the handshake, then predict its result
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [WORD_W-1:0] value,
                            input logic [POS_W-1:0] pos);
        // random idle cycles ahead of the word
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, pos, value};
        i_s_axis_tuser  <= kind;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        pending_results.push_back(deque_apply(kind, value, pos));
    endtask

    // word biased towards the extremes now and then
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(3))
                0: w = 32'h8000_0000;
                1: w = 32'h7fff_ffff;
                2: w = 32'h0000_0000;
                default: w = 32'hffff_ffff;
            endcase
        end
        return w;
    endfunction

    // receiver: random idling, plus a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_left = hold_cycles;
            hold_cycles = 0;
        end
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker: every accepted word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending", o_m_axis_tdata[31:0], '0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== oldest_result.value)
                    report_mismatch("read_value", o_m_axis_tdata[31:0], oldest_result.value);
                if (o_m_axis_tdata[33:32] !== oldest_result.status)
                    report_mismatch("status", 32'(o_m_axis_tdata[33:32]),
                                    32'(oldest_result.status));
                if (o_m_axis_tdata[38:34] !== oldest_result.count)
                    report_mismatch("count", 32'(o_m_axis_tdata[38:34]),
                                    32'(oldest_result.count));
                if (o_m_axis_tdata[39] !== oldest_result.empty)
                    report_mismatch("is_empty", 32'(o_m_axis_tdata[39]),
                                    32'(oldest_result.empty));
            end
        end
    end

    // corner cases: empty list, spare codes, word and position extremes
    task automatic test_directed();
        send_req(REQ_REM_FRONT, 32'h1234_5678, 4'd0);
        send_req(REQ_REM_BACK, 32'h8765_4321, 4'd15);
        send_req(REQ_READ_POS, '0, 4'd0);
        send_req(REQ_READ_POS, '1, 4'd15);
        // spare request codes above read position
        for (int c = int'(REQ_READ_POS) + 1; c <= int'({REQ_W{1'b1}}); c++)
            send_req(c[REQ_W-1:0], 32'hffff_ffff, 4'd15);
        // add back allowed on an empty list
        send_req(REQ_ADD_BACK, 32'h7fff_ffff, 4'd15);
        send_req(REQ_ADD_FRONT, 32'h8000_0000, 4'd0);
        send_req(REQ_ADD_BACK, 32'h0000_0000, 4'd7);
        send_req(REQ_ADD_FRONT, 32'hffff_ffff, 4'd8);
        send_req(REQ_READ_POS, '0, 4'd0);
        send_req(REQ_READ_POS, '0, 4'd3);
        send_req(REQ_READ_POS, '0, 4'd4);
        send_req(REQ_READ_POS, '0, 4'd15);
        send_req(REQ_REM_BACK, '0, 4'd0);
        // front removal drops the first element
        send_req(REQ_REM_FRONT, '0, 4'd0);
        send_req(REQ_REM_FRONT, '0, 4'd0);
        send_req(REQ_REM_BACK, '0, 4'd0);
        send_req(REQ_REM_BACK, '0, 4'd0);
    endtask

    // fill from both ends, push against full, then drain past empty
    task automatic test_fill_and_overflow();
        for (int i = 0; i < DEPTH; i++)
            send_req((i % 2) ? REQ_ADD_FRONT : REQ_ADD_BACK, pick_word(), 4'($urandom));
        send_req(REQ_ADD_FRONT, pick_word(), 4'd0);
        send_req(REQ_ADD_BACK, pick_word(), 4'd0);
        send_req(REQ_READ_POS, '0, 4'd15);
        send_req(REQ_READ_POS, '0, 4'd0);
        for (int i = 0; i < DEPTH; i++)
            send_req((i % 3) ? REQ_REM_FRONT : REQ_REM_BACK, pick_word(), 4'($urandom));
        send_req(REQ_REM_FRONT, '0, 4'd0);
    endtask

    // random traffic that drifts between filling and draining phases
    task automatic test_random(input int n_items);
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        bit   filling;
        int   roll;
        filling = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (list_count >= DEPTH && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (list_count == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            else if ($urandom_range(39) == 0)
                filling = !filling;
            roll = $urandom_range(99);
            if (roll < 5)
                kind = REQ_READ_POS + 3'($urandom_range(1, 3));   // spare codes
            else if (roll < 20)
                kind = REQ_READ_POS;
            else if (roll < (filling ? 75 : 40))
                kind = $urandom_range(1) ? REQ_ADD_FRONT : REQ_ADD_BACK;
            else
                kind = $urandom_range(1) ? REQ_REM_FRONT : REQ_REM_BACK;
            // positions mostly inside the list, sometimes anywhere
            if (list_count > 0 && $urandom_range(4) != 0)
                pos = 4'($urandom_range(list_count - 1));
            else
                pos = 4'($urandom);
            send_req(kind, pick_word(), pos);
        end
    endtask

    // receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 200;
        for (int i = 0; i < 24; i++) begin
            if (i % 4 == 3)
                send_req(REQ_READ_POS, pick_word(), 4'($urandom));
            else
                send_req((list_count < DEPTH) ? REQ_ADD_BACK : REQ_REM_FRONT,
                         pick_word(), 4'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 16;
        recv_idle_pct = 64;
        test_directed();
        test_fill_and_overflow();
        test_random(440);

        // the other way round
        send_idle_pct = 64;
        recv_idle_pct = 16;
        test_random(440);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(440);

        test_backpressure();

        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        // go on waiting to catch any stray result word
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_array_deque_top.sv
verif/bounded_array_deque_top_test.sv
